### design/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, controller states and the command/status bundles of the
// modular exponentiation block.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int VALUE_BITS   = 32;
    localparam int RESULT_BITS  = 31;
    localparam int APB_DATA     = 32;
    localparam int APB_ADDR     = 3;
    localparam int CNT_MAX      = (VALUE_BITS > OPERAND_BITS) ? VALUE_BITS : OPERAND_BITS;
    localparam int CNT_BITS     = $clog2(CNT_MAX);

    localparam logic [OPERAND_BITS-1:0] EXP_RESET = OPERAND_BITS'(1);
    localparam logic [OPERAND_BITS-1:0] MOD_RESET = OPERAND_BITS'(64'h7FFF_FFFF);

    typedef enum logic [0:0] {
        REG_EXPONENT = 1'b0,
        REG_MODULUS  = 1'b1
    } mec_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_FIX,
        ST_EXP,
        ST_MUL,
        ST_MUL_ST,
        ST_SQR,
        ST_SQR_ST,
        ST_DONE
    } mec_state_t;

    typedef struct packed {
        logic load;
        logic red_step;
        logic fix;
        logic mul_start;
        logic mul_step;
        logic mul_sel_sq;
        logic store_acc;
        logic store_base;
        logic exp_shift;
        logic out_load;
    } mec_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_bit0;
        logic exp_last;
        logic red_done;
        logic mul_done;
        logic mod_le1;
    } mec_stat_t;

endpackage

### design/modular_exponentiation_cipher.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_cipher
// Raises each request's base to the configured exponent modulo the configured
// modulus (right-to-left square-and-multiply, shift-and-add products).
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    value  (32b signed)
//   out      out  out_valid/out_ready  result (31b)
//   cfg      in   APB psel/penable     exponent @0x0, modulus @0x4
//
// Each request takes a square for each exponent bit below the highest set bit
// and a multiply for each set bit; a modulus of 0 or 1 skips both. The shared
// modular multiplier consumes one multiplier bit per cycle. rst_n clears
// control state and loads exponent 1, modulus 2^31-1. A result waits in the
// output register; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module modular_exponentiation_cipher
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [mec_pkg::VALUE_BITS-1:0] value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mec_pkg::RESULT_BITS-1:0]       result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mec_pkg::APB_ADDR-1:0]          paddr,
    input  logic [mec_pkg::APB_DATA-1:0]          pwdata,
    output logic [mec_pkg::APB_DATA-1:0]          prdata,
    output logic                                  pready
);
    import mec_pkg::*;

    logic [OPERAND_BITS-1:0] exponent_reg;
    logic [OPERAND_BITS-1:0] modulus_reg;
    logic                    cfg_wr;
    mec_reg_t                cfg_sel;
    mec_cmd_t                cmd;
    mec_stat_t               stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = mec_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXP_RESET;
            modulus_reg  <= MOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_EXPONENT: exponent_reg <= OPERAND_BITS'(pwdata);
                REG_MODULUS:  modulus_reg  <= OPERAND_BITS'(pwdata);
                default:      exponent_reg <= exponent_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_EXPONENT: prdata = APB_DATA'(exponent_reg);
            REG_MODULUS:  prdata = APB_DATA'(modulus_reg);
            default:      prdata = '0;
        endcase
    end

    mec_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mec_dp u_dp
    (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .value    (value),
        .exponent (exponent_reg),
        .modulus  (modulus_reg),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted but controller still ready");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && modulus_reg != '0) |-> (OPERAND_BITS'(result) < modulus_reg))
        else $error("result not reduced below modulus");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a finished computation");
`endif

endmodule

### design/mec_dp.sv
// ----------------------------------------------------------------------------
// mec_dp
// Datapath: bit-serial base reduction and a shared shift-and-add modular
// multiplier used for both multiply and square steps.
// ----------------------------------------------------------------------------
module mec_dp
(
    input  logic                                 clk,
    input  mec_pkg::mec_cmd_t                    cmd,
    output mec_pkg::mec_stat_t                   stat,
    input  logic signed [mec_pkg::VALUE_BITS-1:0] value,
    input  logic [mec_pkg::OPERAND_BITS-1:0]      exponent,
    input  logic [mec_pkg::OPERAND_BITS-1:0]      modulus,
    output logic [mec_pkg::RESULT_BITS-1:0]       result
);
    import mec_pkg::*;

    localparam int W = OPERAND_BITS;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [W-1:0]          mod_reg, mod_next;
    logic [W-1:0]          exp_reg, exp_next;
    logic [W-1:0]          rem_reg, rem_next;
    logic [W-1:0]          base_reg, base_next;
    logic [W-1:0]          acc_reg, acc_next;
    logic [W-1:0]          prod_reg, prod_next;
    logic [W-1:0]          mshift_reg, mshift_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [RESULT_BITS-1:0] result_reg, result_next;

    logic [W:0]   m_ext;
    logic [W:0]   red_t;
    logic [W:0]   dbl;
    logic [W:0]   dbl_r;
    logic [W-1:0] addend;
    logic [W:0]   sum;
    logic [W:0]   sum_r;
    logic [W-1:0] mul_out;

    assign m_ext = {1'b0, mod_reg};
    assign red_t = {rem_reg, mag_reg[VALUE_BITS-1]};

    always_comb
    begin
        dbl     = {prod_reg, 1'b0};
        dbl_r   = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        addend  = mshift_reg[W-1] ? (cmd.mul_sel_sq ? base_reg : acc_reg) : '0;
        sum     = dbl_r + {1'b0, addend};
        sum_r   = (sum >= m_ext) ? (sum - m_ext) : sum;
        mul_out = sum_r[W-1:0];
    end

    always_comb
    begin
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        mod_next    = mod_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        mshift_next = mshift_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            neg_next = value[VALUE_BITS-1];
            mag_next = value[VALUE_BITS-1] ? (~$unsigned(value) + 1'b1) : $unsigned(value);
            mod_next = modulus;
            exp_next = exponent;
            rem_next = '0;
            cnt_next = '0;
        end
        if (cmd.red_step)
        begin
            rem_next = (red_t >= m_ext) ? W'(red_t - m_ext) : W'(red_t);
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.fix)
        begin
            base_next = (neg_reg && rem_reg != '0) ? (mod_reg - rem_reg) : rem_reg;
            acc_next  = W'(1);
        end
        if (cmd.mul_start)
        begin
            prod_next   = '0;
            mshift_next = base_reg;
            cnt_next    = '0;
        end
        if (cmd.mul_step)
        begin
            prod_next   = mul_out;
            mshift_next = {mshift_reg[W-2:0], 1'b0};
            cnt_next    = cnt_reg + 1'b1;
        end
        if (cmd.store_acc)
        begin
            acc_next = prod_reg;
        end
        if (cmd.store_base)
        begin
            base_next = prod_reg;
        end
        if (cmd.exp_shift)
        begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.out_load)
        begin
            result_next = (mod_reg <= W'(1)) ? '0 : RESULT_BITS'(acc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        mod_reg    <= mod_next;
        exp_reg    <= exp_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        mshift_reg <= mshift_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign stat.exp_zero = (exp_reg == '0);
    assign stat.exp_bit0 = exp_reg[0];
    assign stat.exp_last = ((exp_reg >> 1) == '0);
    assign stat.red_done = (cnt_reg == CNT_BITS'(VALUE_BITS - 1));
    assign stat.mul_done = (cnt_reg == CNT_BITS'(W - 1));
    assign stat.mod_le1  = (mod_reg <= W'(1));

    assign result = result_reg;

endmodule

### design/mec_ctrl.sv
// ----------------------------------------------------------------------------
// mec_ctrl
// Controller: sequences reduction, multiply and square steps, and owns the
// request handshakes.
// ----------------------------------------------------------------------------
module mec_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mec_pkg::mec_stat_t stat,
    output mec_pkg::mec_cmd_t  cmd
);
    import mec_pkg::*;

    mec_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = ST_RED;
                end
            ST_RED:
                if (stat.red_done)
                begin
                    state_next = ST_FIX;
                end
            ST_FIX:
                state_next = stat.mod_le1 ? ST_DONE : ST_EXP;
            ST_EXP:
                priority if (stat.exp_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.exp_bit0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_SQR;
                end
            ST_MUL:
                if (stat.mul_done)
                begin
                    state_next = ST_MUL_ST;
                end
            ST_MUL_ST:
                state_next = stat.exp_last ? ST_DONE : ST_SQR;
            ST_SQR:
                if (stat.mul_done)
                begin
                    state_next = ST_SQR_ST;
                end
            ST_SQR_ST:
                state_next = ST_EXP;
            ST_DONE:
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
                cmd.load = in_valid;
            ST_RED:
                cmd.red_step = 1'b1;
            ST_FIX:
                cmd.fix = 1'b1;
            ST_EXP:
                cmd.mul_start = !stat.exp_zero;
            ST_MUL:
                cmd.mul_step = 1'b1;
            ST_MUL_ST:
            begin
                cmd.store_acc = 1'b1;
                cmd.exp_shift = stat.exp_last;
                cmd.mul_start = !stat.exp_last;
            end
            ST_SQR:
            begin
                cmd.mul_step   = 1'b1;
                cmd.mul_sel_sq = 1'b1;
            end
            ST_SQR_ST:
            begin
                cmd.store_base = 1'b1;
                cmd.exp_shift  = 1'b1;
            end
            ST_DONE:
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
